[rtl/gmt_pkg.sv]
// shared types, constants and angle tables for the mercator tile converter
package gmt_pkg;

    localparam int MAX_ZOOM  = 24;
    localparam int FRAC_BITS = 16;
    localparam int SPAN_MAX  = MAX_ZOOM + FRAC_BITS;
    localparam int CW        = 36;

    typedef logic signed [CW-1:0] cw_t;

    localparam cw_t ONE_Q30     = cw_t'(64'd1 << 30);
    localparam cw_t CORDIC_K    = cw_t'(652032874);
    localparam logic [26:0] D2R = 27'd74961321;
    localparam logic signed [31:0] I2P = 32'sd683565276;
    localparam logic [28:0] LN2_HALF   = 29'd372130559;
    localparam logic [30:0] LAT_LIMIT  = 31'd713460579;
    localparam logic signed [32:0] XQ_OFFSET = 33'sd1509949440;
    localparam logic signed [32:0] XQ_SPAN   = 33'sd3019898880;
    localparam logic [31:0] RECIP45 = 32'd3054198966;

    localparam logic [31:0] CIRC_TAB [11] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149, 32'd1048575
    };

    localparam logic [31:0] HYP_TAB [11] = '{
        32'd0, 32'd589812981, 32'd274247419, 32'd134923406, 32'd67196451,
        32'd33565361, 32'd16778582, 32'd8388779, 32'd4194325, 32'd2097155, 32'd1048576
    };

    function automatic cw_t circ_angle(input int i);
        if (i <= 10)
            return cw_t'({4'b0, CIRC_TAB[i]});
        else if (i <= 30)
            return cw_t'(64'd1 << (30 - i));
        else
            return '0;
    endfunction

    function automatic cw_t hyp_angle(input int i);
        if (i <= 10)
            return cw_t'({4'b0, HYP_TAB[i]});
        else if (i <= 30)
            return cw_t'(64'd1 << (30 - i));
        else
            return '0;
    endfunction

    function automatic int hyp_steps(input int n);
        int c;
        c = n;
        if (n >= 4) c = c + 1;
        if (n >= 13) c = c + 1;
        if (n >= 40) c = c + 1;
        return c;
    endfunction

    function automatic int hyp_index(input int j);
        int c;
        c = 0;
        for (int i = 1; i <= 41; i++)
        begin
            if (c == j) return i;
            c = c + 1;
            if (i == 4 || i == 13 || i == 40)
            begin
                if (c == j) return i;
                c = c + 1;
            end
        end
        return 41;
    endfunction

    function automatic logic [SPAN_MAX-1:0] pmax_of(input logic [4:0] z);
        logic [SPAN_MAX:0] p;
        p = ((SPAN_MAX+1)'(1) << (6'(z) + 6'(FRAC_BITS))) - (SPAN_MAX+1)'(1);
        return p[SPAN_MAX-1:0];
    endfunction

endpackage

[rtl/gmt_cordic_circ.sv]
// pipelined circular cordic in rotation mode, one stage per iteration
module gmt_cordic_circ #(
    parameter int STAGES = 28
) (
    input  logic         clk,
    input  logic         en,
    input  gmt_pkg::cw_t phi,
    output gmt_pkg::cw_t sine
);
    import gmt_pkg::*;

    cw_t x_reg [STAGES-1];
    cw_t z_reg [STAGES-1];
    cw_t y_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : stg
        cw_t xi, yi, zi, x_next, y_next, z_next;
        if (g == 0)
        begin : first
            assign xi = CORDIC_K;
            assign yi = '0;
            assign zi = phi;
        end
        else
        begin : later
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
        end

        always_comb
        begin
            if (!zi[CW-1])
            begin
                x_next = xi - (yi >>> g);
                y_next = yi + (xi >>> g);
                z_next = zi - circ_angle(g);
            end
            else
            begin
                x_next = xi + (yi >>> g);
                y_next = yi - (xi >>> g);
                z_next = zi + circ_angle(g);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                y_reg[g] <= y_next;
        end

        if (g < STAGES - 1)
        begin : keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g] <= x_next;
                    z_reg[g] <= z_next;
                end
            end
        end
    end

    assign sine = y_reg[STAGES-1];

endmodule

[rtl/gmt_cordic_hyp.sv]
// pipelined hyperbolic cordic in vectoring mode with repeated iterations
module gmt_cordic_hyp #(
    parameter int STAGES = 28
) (
    input  logic         clk,
    input  logic         en,
    input  gmt_pkg::cw_t a,
    input  gmt_pkg::cw_t b,
    output gmt_pkg::cw_t angle
);
    import gmt_pkg::*;

    localparam int H = hyp_steps(STAGES);

    cw_t x_reg [H-1];
    cw_t y_reg [H-1];
    cw_t z_reg [H];

    for (genvar g = 0; g < H; g++)
    begin : stg
        localparam int I = hyp_index(g);
        cw_t xi, yi, zi, x_next, y_next, z_next;
        if (g == 0)
        begin : first
            assign xi = a + b;
            assign yi = a - b;
            assign zi = '0;
        end
        else
        begin : later
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
        end

        always_comb
        begin
            if (!yi[CW-1])
            begin
                x_next = xi - (yi >>> I);
                y_next = yi - (xi >>> I);
                z_next = zi + hyp_angle(I);
            end
            else
            begin
                x_next = xi + (yi >>> I);
                y_next = yi + (xi >>> I);
                z_next = zi - hyp_angle(I);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                z_reg[g] <= z_next;
        end

        if (g < H - 1)
        begin : keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g] <= x_next;
                    y_reg[g] <= y_next;
                end
            end
        end
    end

    assign angle = z_reg[H-1];

endmodule

[rtl/geo_to_mercator_tile.sv]
// top level: geographic point to web mercator tile column, row and in-tile position
// throughput: one transaction per cycle unless stalled, set by both cordic pipelines
// the whole pipeline holds while a finished result is stalled at the output
// reset clears the stage valid bits only; payload registers are not reset
module geo_to_mercator_tile #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] lat_deg,
    input  logic [31:0] lon_deg,
    input  logic [4:0]  zoom,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] tile_x,
    output logic [23:0] tile_y,
    output logic [15:0] frac_x,
    output logic [15:0] frac_y,
    output logic        edge_clamped
);
    import gmt_pkg::*;

    localparam int H   = hyp_steps(CORDIC_STAGES);
    localparam int SB  = CORDIC_STAGES + H + 6;
    localparam int LAT = SB + 1;

    typedef struct packed {
        logic       neg;
        logic       latc;
        logic [4:0] zoom;
    } side_t;

    typedef struct packed {
        logic                neg;
        logic                latc;
        logic [4:0]          zoom;
        logic [SPAN_MAX-1:0] px;
        logic                xflag;
    } sb_t;

    logic adv;
    logic [LAT:1] vld_reg;

    assign adv       = !(vld_reg[LAT] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-1:1], in_valid};
    end

    // stage 1: input capture
    logic signed [32:0] xq1_reg;
    logic [30:0] mag1_reg;
    side_t side1_reg;
    logic [4:0] zoom_sat;
    logic [30:0] mag_next;

    always_comb
    begin
        zoom_sat = (zoom > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom;
        mag_next = lat_deg[30] ? 31'(-lat_deg) : lat_deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xq1_reg        <= $signed({lon_deg[31], lon_deg}) + XQ_OFFSET;
            mag1_reg       <= mag_next;
            side1_reg.neg  <= lat_deg[30];
            side1_reg.latc <= mag_next > LAT_LIMIT;
            side1_reg.zoom <= zoom_sat;
        end
    end

    // stage 2: first reciprocal multiply, angle in radians
    logic [31:0] xu2_reg;
    logic [26:0] q1e2_reg;
    logic xlo2_reg, xhi2_reg;
    cw_t phi2_reg;
    side_t side2_reg;
    logic [63:0] prod1;
    logic [57:0] phi_prod;

    always_comb
    begin
        prod1    = 64'(xq1_reg[31:0]) * 64'(RECIP45);
        phi_prod = 58'(mag1_reg) * 58'(D2R) + (58'd1 << 24);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xu2_reg   <= xq1_reg[31:0];
            q1e2_reg  <= prod1[63:37];
            xlo2_reg  <= xq1_reg[32];
            xhi2_reg  <= !xq1_reg[32] && (xq1_reg >= XQ_SPAN);
            phi2_reg  <= cw_t'({3'b0, phi_prod[57:25]});
            side2_reg <= side1_reg;
        end
    end

    // stage 3: quotient correction
    logic [25:0] q1_3_reg;
    logic [5:0] r1_3_reg;
    logic xlo3_reg, xhi3_reg;
    side_t side3_reg;
    logic [32:0] r1_full;

    assign r1_full = {1'b0, xu2_reg} - 33'(q1e2_reg) * 33'd45;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (r1_full[6:0] >= 7'd45)
            begin
                q1_3_reg <= 26'(q1e2_reg + 27'd1);
                r1_3_reg <= 6'(r1_full[6:0] - 7'd45);
            end
            else
            begin
                q1_3_reg <= q1e2_reg[25:0];
                r1_3_reg <= r1_full[5:0];
            end
            xlo3_reg  <= xlo2_reg;
            xhi3_reg  <= xhi2_reg;
            side3_reg <= side2_reg;
        end
    end

    // stage 4: remainder fraction multiply
    logic [25:0] q1_4_reg;
    logic [19:0] n2_4_reg;
    logic [14:0] q2e4_reg;
    logic xlo4_reg, xhi4_reg;
    side_t side4_reg;
    logic [19:0] n2;
    logic [51:0] prod2;

    always_comb
    begin
        n2    = {r1_3_reg, 14'b0};
        prod2 = 52'(n2) * 52'(RECIP45);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_4_reg  <= q1_3_reg;
            n2_4_reg  <= n2;
            q2e4_reg  <= prod2[51:37];
            xlo4_reg  <= xlo3_reg;
            xhi4_reg  <= xhi3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: assemble full-resolution x
    logic [SPAN_MAX-1:0] r5_reg;
    logic xlo5_reg, xhi5_reg;
    side_t side5_reg;
    logic [20:0] r2_full;
    logic [13:0] q2;

    always_comb
    begin
        r2_full = {1'b0, n2_4_reg} - 21'(q2e4_reg) * 21'd45;
        q2 = (r2_full[6:0] >= 7'd45) ? 14'(q2e4_reg + 15'd1) : q2e4_reg[13:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_reg    <= {q1_4_reg, q2};
            xlo5_reg  <= xlo4_reg;
            xhi5_reg  <= xhi4_reg;
            side5_reg <= side4_reg;
        end
    end

    // stage 6 on: x result and side data ride along the y pipeline
    sb_t sb_reg [6:SB];
    sb_t sb6_next;

    always_comb
    begin
        sb6_next.neg  = side5_reg.neg;
        sb6_next.latc = side5_reg.latc;
        sb6_next.zoom = side5_reg.zoom;
        if (xlo5_reg)
        begin
            sb6_next.px    = '0;
            sb6_next.xflag = 1'b1;
        end
        else if (xhi5_reg)
        begin
            sb6_next.px    = pmax_of(side5_reg.zoom);
            sb6_next.xflag = 1'b1;
        end
        else
        begin
            sb6_next.px    = r5_reg >> (5'(MAX_ZOOM) - side5_reg.zoom);
            sb6_next.xflag = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[6] <= sb6_next;
            for (int i = 7; i <= SB; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // y path: sine of latitude
    cw_t sine;

    gmt_cordic_circ #(.STAGES(CORDIC_STAGES)) u_circ (
        .clk  (clk),
        .en   (adv),
        .phi  (phi2_reg),
        .sine (sine)
    );

    // normalize 1 - sin to at least one half, first pass
    cw_t a_n1_reg;
    logic [30:0] b_n1_reg;
    logic [4:0] k_n1_reg;
    cw_t b_full;
    logic [30:0] b_a;
    logic [4:0] k_a;

    always_comb
    begin
        b_full = ONE_Q30 - sine;
        if (b_full[CW-1] || b_full == '0)
            b_a = 31'd1;
        else
            b_a = b_full[30:0];
        k_a = '0;
        if (b_a < (31'd1 << 14))
        begin
            b_a = b_a << 16;
            k_a = k_a + 5'd16;
        end
        if (b_a < (31'd1 << 22))
        begin
            b_a = b_a << 8;
            k_a = k_a + 5'd8;
        end
        if (b_a < (31'd1 << 26))
        begin
            b_a = b_a << 4;
            k_a = k_a + 5'd4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_n1_reg <= ONE_Q30 + sine;
            b_n1_reg <= b_a;
            k_n1_reg <= k_a;
        end
    end

    // normalize, second pass
    cw_t a_n2_reg;
    logic [30:0] b_n2_reg;
    logic [4:0] k_b;
    logic [30:0] b_b;

    always_comb
    begin
        b_b = b_n1_reg;
        k_b = k_n1_reg;
        if (b_b < (31'd1 << 28))
        begin
            b_b = b_b << 2;
            k_b = k_b + 5'd2;
        end
        if (b_b < (31'd1 << 29))
        begin
            b_b = b_b << 1;
            k_b = k_b + 5'd1;
        end
    end

    logic [4:0] k_reg [0:H];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_n2_reg <= a_n1_reg;
            b_n2_reg <= b_b;
            k_reg[0] <= k_b;
            for (int i = 1; i <= H; i++)
                k_reg[i] <= k_reg[i-1];
        end
    end

    cw_t hz;

    gmt_cordic_hyp #(.STAGES(CORDIC_STAGES)) u_hyp (
        .clk   (clk),
        .en    (adv),
        .a     (a_n2_reg),
        .b     (cw_t'({5'b0, b_n2_reg})),
        .angle (hz)
    );

    // artanh total, sign
    logic signed [33:0] ym_reg;
    logic [35:0] k_ln2;
    cw_t ym;

    always_comb
    begin
        k_ln2 = 36'(k_reg[H]) * 36'(LN2_HALF);
        ym = hz + $signed(k_ln2);
        if (sb_reg[CORDIC_STAGES + H + 4].neg)
            ym = -ym;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ym_reg <= ym[33:0];
    end

    // scale by 1/(2 pi)
    logic signed [33:0] t_reg;
    logic signed [65:0] t_prod;

    assign t_prod = 66'(ym_reg) * 66'(I2P) + (66'sd1 <<< 31);

    always_ff @(posedge clk)
    begin
        if (adv)
            t_reg <= t_prod[65:32];
    end

    // output stage
    logic signed [34:0] v;
    logic [55:0] py_wide;
    logic [41:0] py_full;
    logic [SPAN_MAX-1:0] pmax, py;
    logic yflag;
    sb_t sbo;

    always_comb
    begin
        sbo     = sb_reg[SB];
        pmax    = pmax_of(sbo.zoom);
        v       = (35'sd1 <<< 29) - 35'(t_reg);
        py_wide = 56'(v[31:0]) << sbo.zoom;
        py_full = py_wide[55:14];
        if (sbo.latc)
        begin
            py    = sbo.neg ? pmax : '0;
            yflag = 1'b1;
        end
        else if (v[34])
        begin
            py    = '0;
            yflag = 1'b1;
        end
        else if (py_full > 42'(pmax))
        begin
            py    = pmax;
            yflag = 1'b1;
        end
        else
        begin
            py    = py_full[SPAN_MAX-1:0];
            yflag = 1'b0;
        end
    end

    logic [23:0] tile_x_reg, tile_y_reg;
    logic [15:0] frac_x_reg, frac_y_reg;
    logic edge_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tile_x_reg <= sbo.px[SPAN_MAX-1:FRAC_BITS];
            tile_y_reg <= py[SPAN_MAX-1:FRAC_BITS];
            frac_x_reg <= sbo.px[FRAC_BITS-1:0];
            frac_y_reg <= py[FRAC_BITS-1:0];
            edge_reg   <= sbo.xflag || yflag;
        end
    end

    assign tile_x       = tile_x_reg;
    assign tile_y       = tile_y_reg;
    assign frac_x       = frac_x_reg;
    assign frac_y       = frac_y_reg;
    assign edge_clamped = edge_reg;

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(vld_reg[LAT-1]))
        else $error("output valid without a transaction in the last stage");

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && !sb_reg[6].xflag |->
            (sb_reg[6].px >> (6'(sb_reg[6].zoom) + 6'(FRAC_BITS))) == '0)
        else $error("unclamped x beyond map width");

endmodule

[tb/geo_to_mercator_tile_chk.sv]
// transaction checker for the mercator tile converter: predicts each result and compares
`timescale 1ns / 1ps

module geo_to_mercator_tile_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [30:0] lat_deg,
    input  logic [31:0] lon_deg,
    input  logic [4:0]  zoom,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [23:0] tile_x,
    input  logic [23:0] tile_y,
    input  logic [15:0] frac_x,
    input  logic [15:0] frac_y,
    input  logic        edge_clamped,
    output int          pending_tiles,
    output int          mismatch_count
);

    import gmt_pkg::MAX_ZOOM;
    import gmt_pkg::FRAC_BITS;

    localparam int STAGES = 28;
    localparam longint K_GAIN = 652032874;
    localparam longint DEG_TO_RAD = 74961321;
    localparam longint INV_TWO_PI = 683565276;
    localparam longint HALF_LN2 = 372130559;
    localparam longint LAT_MAX = 713460579;
    localparam longint LON_OFFSET = 1509949440;
    localparam longint LON_SPAN = 64'sd3019898880;
    localparam longint UNIT = 64'sd1 << 30;

    localparam longint CIRC_ATAN [11] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575
    };
    localparam longint HYP_ATANH [11] = '{
        0, 589812981, 274247419, 134923406, 67196451,
        33565361, 16778582, 8388779, 4194325, 2097155, 1048576
    };

    typedef struct packed {
        logic [23:0] tx;
        logic [23:0] ty;
        logic [15:0] fx;
        logic [15:0] fy;
        logic        clamp;
    } tile_t;

    tile_t tile_q[$];

    function automatic longint rot_angle(int i, bit hyp);
        if (i <= 10)
            return hyp ? HYP_ATANH[i] : CIRC_ATAN[i];
        else if (i <= 30)
            return 64'sd1 << (30 - i);
        return 0;
    endfunction

    function automatic tile_t predict_tile(logic [30:0] lat_in, logic [31:0] lon_in,
                                           logic [4:0] zin);
        longint lat, lon, xq, mag, phi, cx, cy, cz, dx, dy, s, a, b;
        longint hx, hy, hz, ym, t, v;
        longint unsigned pmax, px, py;
        int zm, span, k, reps;
        bit neg, flag;
        tile_t r;
        lat = longint'($signed(lat_in));
        lon = longint'($signed(lon_in));
        zm = (zin > MAX_ZOOM) ? MAX_ZOOM : int'(zin);
        span = zm + FRAC_BITS;
        pmax = (64'd1 << span) - 1;
        flag = 0;

        xq = lon + LON_OFFSET;
        if (xq < 0)
        begin
            px = 0;
            flag = 1;
        end
        else if (xq >= LON_SPAN)
        begin
            px = pmax;
            flag = 1;
        end
        else if (span >= 23)
            px = (longint'(unsigned'(xq)) << (span - 23)) / 360;
        else
            px = xq / (64'd360 << (23 - span));

        neg = lat < 0;
        mag = neg ? -lat : lat;
        if (mag > LAT_MAX)
        begin
            py = neg ? pmax : 0;
            flag = 1;
        end
        else
        begin
            phi = (mag * DEG_TO_RAD + (64'sd1 << 24)) >> 25;
            cx = K_GAIN;
            cy = 0;
            cz = phi;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cz >= 0)
                begin
                    cx -= dx; cy += dy; cz -= rot_angle(i, 0);
                end
                else
                begin
                    cx += dx; cy -= dy; cz += rot_angle(i, 0);
                end
            end
            s = cy;
            a = UNIT + s;
            b = UNIT - s;
            if (b <= 0) b = 1;
            k = 0;
            while (b < (UNIT >> 1) && k < 40)
            begin
                b = b << 1;
                k++;
            end
            hx = a + b;
            hy = a - b;
            hz = 0;
            for (int i = 1; i <= STAGES; i++)
            begin
                reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
                for (int j = 0; j < reps; j++)
                begin
                    dx = hy >>> i;
                    dy = hx >>> i;
                    if (hy >= 0)
                    begin
                        hx -= dx; hy -= dy; hz += rot_angle(i, 1);
                    end
                    else
                    begin
                        hx += dx; hy += dy; hz -= rot_angle(i, 1);
                    end
                end
            end
            ym = hz + longint'(k) * HALF_LN2;
            if (neg) ym = -ym;
            t = (ym * INV_TWO_PI + (64'sd1 << 31)) >>> 32;
            v = (UNIT >> 1) - t;
            if (v < 0)
            begin
                py = 0;
                flag = 1;
            end
            else
            begin
                py = (longint'(unsigned'(v)) << zm) >> (30 - FRAC_BITS);
                if (py > pmax)
                begin
                    py = pmax;
                    flag = 1;
                end
            end
        end

        r.tx = px[FRAC_BITS +: 24];
        r.ty = py[FRAC_BITS +: 24];
        r.fx = px[15:0];
        r.fy = py[15:0];
        r.clamp = flag;
        return r;
    endfunction

    initial
    begin
        pending_tiles = 0;
        mismatch_count = 0;
    end

    always @(posedge clk)
    begin
        tile_t got, want;
        if (rst_n && in_valid && !in_stall)
            tile_q.push_back(predict_tile(lat_deg, lon_deg, zoom));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{tile_x, tile_y, frac_x, frac_y, edge_clamped};
            if (tile_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: got %p", got);
            end
            else
            begin
                want = tile_q.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        pending_tiles = tile_q.size();
    end

endmodule

[tb/geo_to_mercator_tile_tb.sv]
// testbench top for the mercator tile converter: stimulus, stalls and verdict
`timescale 1ns / 1ps

module geo_to_mercator_tile_tb;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [30:0] lat_deg = '0;
    logic [31:0] lon_deg = '0;
    logic [4:0]  zoom = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [23:0] tile_x;
    logic [23:0] tile_y;
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    logic        edge_clamped;
    int          pending_tiles;
    int          mismatch_count;
    bit          calm = 0;
    int          stall_left = 0;
    int          free_left = 0;

    geo_to_mercator_tile u_dut (.*);

    geo_to_mercator_tile_chk u_chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 0;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            out_stall <= 1;
        end
        else
        begin
            free_left = $urandom_range(0, 20);
            out_stall <= 0;
        end
    end

    task automatic send_point(logic [30:0] lat, logic [31:0] lon, logic [4:0] z);
        lat_deg <= lat;
        lon_deg <= lon;
        zoom <= z;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    function automatic logic [30:0] pick_lat();
        case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1: return $urandom_range(0, 1) ? 31'(713460579) : 31'(-713460579);
            2: return 31'($signed($urandom_range(0, 40)) - 20 + 713460579);
            default: return 31'($signed($urandom_range(0, 1426921158)) - 713460579);
        endcase
    endfunction

    function automatic logic [31:0] pick_lon();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20 + 1509949440);
            2: return 32'($signed($urandom_range(0, 40)) - 20 - 1509949440);
            default: return 32'($signed($urandom_range(0, 32'd3019898879)) - 1509949440);
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // field extremes, map edges, zoom saturation
        send_point('0, '0, 5'd0);
        send_point('0, '0, 5'd24);
        send_point('0, '0, 5'd25);
        send_point('0, '0, 5'd31);
        send_point(31'(713460579), 32'(-1509949440), 5'd24);
        send_point(31'(-713460579), 32'(1509949439), 5'd24);
        send_point(31'(713460580), 32'(1509949440), 5'd10);
        send_point(31'(-713460580), 32'(-1509949441), 5'd10);
        send_point(31'h3fffffff, 32'h7fffffff, 5'd3);
        send_point(31'h40000000, 32'h80000000, 5'd3);
        send_point(31'h7fffffff, 32'hffffffff, 5'd1);
        send_point(31'(754974720), 32'(-1509949440), 5'd7);
        send_point(31'(-754974720), '0, 5'd7);
        send_point(31'(8388608), 32'(8388608), 5'd6);
        send_point(31'(-8388608), 32'(-8388608), 5'd6);
        send_point(31'(377487360), 32'(754974720), 5'd18);
        send_point(31'(-377487360), 32'(-754974720), 5'd18);
        send_point(31'(1), 32'(1), 5'd24);
        send_point(31'h7fffffff, 32'hffffffff, 5'd24);

        // hold off until the pipeline drains
        in_valid <= 0;
        while (pending_tiles != 0) @(posedge clk);

        for (int n = 0; n < 1150; n++)
        begin
            if (n == 1000) calm = 1;
            send_point(pick_lat(), pick_lon(), 5'($urandom_range(0, 31)));
        end
        in_valid <= 0;

        while (pending_tiles != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[geo_to_mercator_tile.f]
rtl/gmt_pkg.sv
rtl/gmt_cordic_circ.sv
rtl/gmt_cordic_hyp.sv
rtl/geo_to_mercator_tile.sv
tb/geo_to_mercator_tile_chk.sv
tb/geo_to_mercator_tile_tb.sv
